>>> rtl/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Shared constants, register map and arctangent table for the pixel to sphere
// ray direction unit.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int OUT_FRAC_BITS = 15;
  localparam int CORDIC_STEPS  = 30;
  localparam int ANGLE_W       = 15;
  localparam int SIZE_W        = 13;
  localparam int IDX_W         = 12;
  localparam int QUO_W         = 29;
  localparam int CW            = 32;

  localparam logic signed [CW-1:0] CORDIC_ONE = 32'sd652032874;
  localparam logic [ANGLE_W-1:0]   HALF_TURN  = 15'd16384;

  typedef enum logic [2:0] {
    REG_AZ_LO  = 3'd0,
    REG_AZ_HI  = 3'd1,
    REG_EL_LO  = 3'd2,
    REG_EL_HI  = 3'd3,
    REG_COLS   = 3'd4,
    REG_ROWS   = 3'd5
  } reg_idx_t;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10679838;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      24: r = 32'sd41;
      25: r = 32'sd20;
      26: r = 32'sd10;
      27: r = 32'sd5;
      28: r = 32'sd3;
      29: r = 32'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/psr_linang.sv
// ----------------------------------------------------------------------------
// psr_linang
// Linear angle law: lo + floor((hi - lo) * (size - 1 - idx) / size) + offset,
// modulo one turn, through a one-bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
module psr_linang #(
  parameter int MaxDim = 4096,
  parameter logic [14:0] AddTurn = 15'd0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [15:0]                lo,
  input  logic signed [15:0]                hi,
  input  logic [psr_pkg::SIZE_W-1:0]        size_raw,
  input  logic [psr_pkg::IDX_W-1:0]         idx,
  output logic [psr_pkg::ANGLE_W-1:0]       angle
);
  import psr_pkg::*;

  logic [SIZE_W-1:0]        sz;
  logic signed [16:0]       dif;
  logic signed [SIZE_W:0]   k;
  logic signed [30:0]       prod;
  logic [30:0]              prod_abs;
  logic signed [30:0]       nreg;

  logic [SIZE_W-1:0]        rem [0:QUO_W-1];
  logic [QUO_W-1:0]         num [0:QUO_W-1];
  logic                     neg [0:QUO_W-1];
  logic [ANGLE_W-1:0]       q_adj;

  always_comb begin
    if (size_raw == '0) begin
      sz = SIZE_W'(1);
    end else if ({19'b0, size_raw} > 32'(MaxDim)) begin
      sz = SIZE_W'(MaxDim);
    end else begin
      sz = size_raw;
    end
    dif      = 17'(hi) - 17'(lo);
    k        = $signed({1'b0, sz}) - 14'sd1 - $signed({2'b00, idx});
    prod     = 31'(dif) * 31'(k);
    prod_abs = nreg[30] ? 31'(-nreg) : 31'(nreg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nreg <= prod;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [SIZE_W:0]  t;
    logic             ge;
    logic [SIZE_W-1:0] rin;
    logic [QUO_W-1:0]  nin;
    logic              sin;
    if (j == 0) begin : g_first
      assign rin = '0;
      assign nin = prod_abs[QUO_W-1:0];
      assign sin = nreg[30];
    end else begin : g_rest
      assign rin = rem[j-1];
      assign nin = num[j-1];
      assign sin = neg[j-1];
    end
    assign t  = {rin, nin[QUO_W-1]};
    assign ge = t >= {1'b0, sz};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? SIZE_W'(t - {1'b0, sz}) : t[SIZE_W-1:0];
        num[j] <= {nin[QUO_W-2:0], ge};
        neg[j] <= sin;
      end
    end
  end

  always_comb begin
    if (neg[QUO_W-1]) begin
      q_adj = ~num[QUO_W-1][ANGLE_W-1:0] + ANGLE_W'(rem[QUO_W-1] == '0);
    end else begin
      q_adj = num[QUO_W-1][ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= lo[ANGLE_W-1:0] + q_adj + AddTurn;
    end
  end

endmodule

>>> rtl/psr_cordic.sv
// ----------------------------------------------------------------------------
// psr_cordic
// Pipelined rotation cordic, one micro-rotation per stage, giving sine and
// cosine in Q30 of a 15-bit binary angle.
// ----------------------------------------------------------------------------
module psr_cordic (
  input  logic                          clk,
  input  logic                          en,
  input  logic [psr_pkg::ANGLE_W-1:0]   angle,
  output logic signed [psr_pkg::CW-1:0] sin_q,
  output logic signed [psr_pkg::CW-1:0] cos_q
);
  import psr_pkg::*;

  logic signed [CW-1:0] xs [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] ys [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] zs [0:CORDIC_STEPS-1];
  logic                 fl [0:CORDIC_STEPS-1];
  logic                 flip0;
  logic signed [CW-1:0] z0;

  always_comb begin
    flip0 = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
    z0    = $signed({angle[ANGLE_W-1] ^ flip0, angle[ANGLE_W-2:0], 17'b0});
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] xi, yi, zi;
    logic                 fi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_ONE;
      assign yi = '0;
      assign zi = z0;
      assign fi = flip0;
    end else begin : g_rest
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign fi = fl[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CW-1]) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - atan_turn(i);
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + atan_turn(i);
        end
        fl[i] <= fi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= fl[CORDIC_STEPS-1] ? -ys[CORDIC_STEPS-1] : ys[CORDIC_STEPS-1];
      cos_q <= fl[CORDIC_STEPS-1] ? -xs[CORDIC_STEPS-1] : xs[CORDIC_STEPS-1];
    end
  end

endmodule

>>> rtl/pixel_to_sphere_ray_direction_unit.sv
// throughput: one word per cycle; the whole pipeline advances together and
//   holds while an output word waits
// the depth comes mainly from the 29-stage angle divider and 30-stage cordic
// reset clears valid bits and loads the default limits and image size
// ----------------------------------------------------------------------------
// pixel_to_sphere_ray_direction_unit
// Equirectangular camera: pixel row and column to unit view direction.
// ----------------------------------------------------------------------------
module pixel_to_sphere_ray_direction_unit #(
  parameter int MaxDim      = psr_pkg::MAX_DIM,
  parameter int OutFracBits = psr_pkg::OUT_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel_row, pixel_col
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // dir_x, dir_y, dir_z
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psr_pkg::*;

  localparam int Lat = 64;
  localparam int PS  = 60 - OutFracBits;
  localparam int YS  = 30 - OutFracBits;

  logic signed [15:0] az_lo, az_hi, el_lo, el_hi;
  logic [SIZE_W-1:0]  cols, rows;
  logic               en;
  logic [Lat-1:0]     vld;
  reg_idx_t           ridx;

  logic [ANGLE_W-1:0]   az_ang, el_ang;
  logic signed [CW-1:0] sa, ca, se, ce;
  logic signed [63:0]   px, pz;
  logic signed [CW-1:0] se_d;
  logic signed [15:0]   ox, oy, oz;

  function automatic logic signed [15:0] sat16(input logic signed [64:0] v);
    if (v > 65'sd32767) begin
      return 16'sh7fff;
    end else if (v < -65'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      az_lo <= -16'sd16384;
      az_hi <= 16'sd16384;
      el_lo <= -16'sd8192;
      el_hi <= 16'sd8192;
      cols  <= SIZE_W'(1024);
      rows  <= SIZE_W'(512);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_AZ_LO: az_lo <= pwdata[15:0];
        REG_AZ_HI: az_hi <= pwdata[15:0];
        REG_EL_LO: el_lo <= pwdata[15:0];
        REG_EL_HI: el_hi <= pwdata[15:0];
        REG_COLS:  cols  <= pwdata[SIZE_W-1:0];
        REG_ROWS:  rows  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_AZ_LO: prdata = {16'b0, az_lo};
      REG_AZ_HI: prdata = {16'b0, az_hi};
      REG_EL_LO: prdata = {16'b0, el_lo};
      REG_EL_HI: prdata = {16'b0, el_hi};
      REG_COLS:  prdata = {19'b0, cols};
      REG_ROWS:  prdata = {19'b0, rows};
      default:   prdata = '0;
    endcase
  end

  assign en       = !vld[Lat-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_tvalid};
    end
  end

  psr_linang #(.MaxDim(MaxDim), .AddTurn(HALF_TURN)) u_az (
    .clk(clk), .en(en), .lo(az_lo), .hi(az_hi), .size_raw(cols),
    .idx(s_tdata[23:12]), .angle(az_ang)
  );

  psr_linang #(.MaxDim(MaxDim), .AddTurn(15'd0)) u_el (
    .clk(clk), .en(en), .lo(el_lo), .hi(el_hi), .size_raw(rows),
    .idx(s_tdata[11:0]), .angle(el_ang)
  );

  psr_cordic u_cz (.clk(clk), .en(en), .angle(az_ang), .sin_q(sa), .cos_q(ca));
  psr_cordic u_ce (.clk(clk), .en(en), .angle(el_ang), .sin_q(se), .cos_q(ce));

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= sa * ce;
      pz   <= ca * ce;
      se_d <= se;
    end
  end

  always_comb begin
    ox = sat16((65'(px) + (65'sd1 <<< (PS - 1))) >>> PS);
    oz = sat16((65'(pz) + (65'sd1 <<< (PS - 1))) >>> PS);
  end

  if (YS > 0) begin : g_yround
    assign oy = sat16((65'(se_d) + (65'sd1 <<< (YS - 1))) >>> YS);
  end else begin : g_yplain
    assign oy = sat16(65'(se_d));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {oz, oy, ox};
    end
  end

`ifndef NO_ASSERTIONS
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted word did not enter the pipeline");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |-> s_tready)
    else $error("pipeline stalled while output drained");
`endif

endmodule
